// ----- rtl/core/deq_pkg.sv -----
// Package for the double-ended queue: operation and status codes,
// default sizes and the per-cell control bundle. No dependencies.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DefaultDepth     = 16;
  localparam int DefaultDataWidth = 32;

  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic shift_in;   // take word from front-side neighbor
    logic shift_out;  // take word from back-side neighbor
    logic write;      // load the pushed word
  } cell_ctrl_t;

endpackage

// ----- rtl/core/double_ended_queue_unit.sv -----
// The result is registered and presented in the cycle after the transaction is accepted;
// throughput is 1 transaction per cycle while the registered result is not stalled by out_ready.
// Storage is a chain of DEPTH cells with the front word in cell 0; push front
// and pop front shift the whole chain by one cell.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// cell contents are not cleared. Depends on deq_pkg and deq_cell.
`timescale 1ns / 1ps

module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int DEPTH      = DefaultDepth,
  parameter int DATA_WIDTH = DefaultDataWidth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [DATA_WIDTH-1:0]         data_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [DATA_WIDTH-1:0]         data_out,
  output logic [1:0]                    status,
  output logic [$clog2(DEPTH+1)-1:0]    occupancy
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         back_pos;
  logic                  accept;
  logic                  empty;
  logic                  full;
  logic                  do_push_front;
  logic                  do_push_back;
  logic                  do_pop_front;
  logic                  do_pop_back;
  logic [DATA_WIDTH-1:0] result_next;
  logic [1:0]            status_next;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  cell_ctrl_t            cell_ctrl [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));
  assign back_pos = count - CW'(1);

  assign do_push_front = accept && (func == OP_PUSH_FRONT) && !full;
  assign do_push_back  = accept && (func == OP_PUSH_BACK) && !full;
  assign do_pop_front  = accept && (func == OP_POP_FRONT) && !empty;
  assign do_pop_back   = accept && (func == OP_POP_BACK) && !empty;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] front_side;
      logic [DATA_WIDTH-1:0] back_side;

      if (i == 0) begin : g_first
        assign front_side = data_in;
      end else begin : g_mid
        assign front_side = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign back_side = cell_data[i];
      end else begin : g_inner
        assign back_side = cell_data[i+1];
      end

      assign cell_ctrl[i].shift_in  = do_push_front;
      assign cell_ctrl[i].shift_out = do_pop_front;
      assign cell_ctrl[i].write     = do_push_back && (count == CW'(i));

      deq_cell #(
        .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .word       (data_in),
        .front_side (front_side),
        .back_side  (back_side),
        .data       (cell_data[i])
      );
    end
  endgenerate

  always_comb begin
    result_next = '0;
    status_next = ST_DONE;
    count_next  = count;
    unique case (func)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          result_next = '1;
          status_next = ST_EMPTY;
        end else begin
          result_next = cell_data[0];
          count_next  = back_pos;
        end
      end
      default: begin
        if (empty) begin
          result_next = '1;
          status_next = ST_EMPTY;
        end else begin
          result_next = cell_data[back_pos[IW-1:0]];
          count_next  = back_pos;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_out  <= result_next;
      status    <= status_next;
      occupancy <= count_next;
    end
  end

endmodule

// ----- rtl/core/deq_cell.sv -----
// One storage cell of the queue chain; shifts toward either neighbor or loads.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_cell
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = DefaultDataWidth
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] front_side,
  input  logic [DATA_WIDTH-1:0] back_side,
  output logic [DATA_WIDTH-1:0] data
);

  always_ff @(posedge clk) begin
    priority if (ctrl.write) begin
      data <= word;
    end else if (ctrl.shift_in) begin
      data <= front_side;
    end else if (ctrl.shift_out) begin
      data <= back_side;
    end else begin
      data <= data;
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench for double_ended_queue_unit: directed and random push/pop traffic
// checked against a ring-buffer predictor, under varied valid/ready idling.
// Depends on deq_pkg and the queue RTL.
`timescale 1ns / 1ps

module tb_top;
  import deq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int OCC_W      = $clog2(DEPTH + 1);
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] word;
    logic [1:0]            st;
    logic [OCC_W-1:0]      occ;
  } deq_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [1:0]            func      = OP_PUSH_FRONT;
  logic [DATA_WIDTH-1:0] data_in   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DATA_WIDTH-1:0] data_out;
  logic [1:0]            status;
  logic [OCC_W-1:0]      occupancy;

  // predictor state: ring of slots, front index, entry count
  logic [DATA_WIDTH-1:0] ring_slot [DEPTH];
  int                    head_idx   = 0;
  int                    fill_count = 0;
  deq_result_t           pending_results [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int quiet_cycles   = 0;
  deq_result_t           want;

  double_ended_queue_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .status    (status),
    .occupancy (occupancy)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic predict_op(input logic [1:0] op, input logic [DATA_WIDTH-1:0] word);
    deq_result_t r;
    r.word = '0;
    r.st   = ST_DONE;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_count >= DEPTH) begin
          r.st = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          head_idx = (head_idx + DEPTH - 1) % DEPTH;
          ring_slot[head_idx] = word;
          fill_count++;
        end else begin
          ring_slot[(head_idx + fill_count) % DEPTH] = word;
          fill_count++;
        end
      end
      default: begin
        if (fill_count == 0) begin
          r.word = '1;
          r.st   = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          r.word   = ring_slot[head_idx];
          head_idx = (head_idx + 1) % DEPTH;
          fill_count--;
        end else begin
          r.word = ring_slot[(head_idx + fill_count - 1) % DEPTH];
          fill_count--;
        end
      end
    endcase
    r.occ = fill_count[OCC_W-1:0];
    pending_results.push_back(r);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [DATA_WIDTH-1:0] word);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    data_in  <= word;
    do @(posedge clk); while (!in_ready);
    predict_op(op, word);
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return {{(DATA_WIDTH-1){1'b0}}, 1'b1} << $urandom_range(DATA_WIDTH - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_pops();
    send_op(OP_POP_FRONT, '1);
    send_op(OP_POP_BACK, '0);
  endtask

  task automatic test_word_extremes();
    send_op(OP_PUSH_FRONT, '0);
    send_op(OP_PUSH_BACK, '1);
    send_op(OP_POP_BACK, $urandom);
    send_op(OP_POP_FRONT, $urandom);
  endtask

  task automatic test_full_pushes();
    for (int k = 0; k < DEPTH; k++) begin
      send_op((k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
    end
    send_op(OP_PUSH_FRONT, 32'hA5A5_5A5A);
    send_op(OP_PUSH_BACK, 32'h5A5A_A5A5);
  endtask

  // random walk over occupancy; push bias changes every burst so the queue
  // swings between empty and full
  task automatic test_random_traffic(input int n_ops, input int s_idle, input int r_stall);
    int push_pct;
    logic is_push;
    logic at_back;
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    push_pct = 50;
    for (int k = 0; k < n_ops; k++) begin
      if (k % 30 == 0) begin
        case ($urandom_range(4))
          0:       push_pct = 10;
          1:       push_pct = 35;
          2:       push_pct = 65;
          3:       push_pct = 90;
          default: push_pct = 50;
        endcase
      end
      is_push = ($urandom_range(99) < push_pct);
      at_back = $urandom_range(1);
      if (is_push) send_op(at_back ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_word());
      else         send_op(at_back ? OP_POP_BACK : OP_POP_FRONT, pick_word());
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result data_out=%h status=%0d occupancy=%0d",
                 $time, data_out, status, occupancy);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (data_out !== want.word) begin
          $display("%0t: data_out exp %h act %h", $time, want.word, data_out);
          error_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status exp %0d act %0d", $time, want.st, status);
          error_count++;
        end
        if (occupancy !== want.occ) begin
          $display("%0t: occupancy exp %0d act %0d", $time, want.occ, occupancy);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d transactions outstanding", $time, pending_results.size());
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_pops();
    test_word_extremes();
    test_full_pushes();
    test_random_traffic(300, 0, 0);
    test_random_traffic(280, 71, 0);
    test_random_traffic(280, 0, 71);
    test_random_traffic(290, 14, 14);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/deq_pkg.sv
rtl/core/deq_cell.sv
rtl/core/double_ended_queue_unit.sv
dv/tb_top.sv
